@@ rtl/core/iba_pkg.sv @@
// Package for the indexed block allocator: sizes, codes and shared types.
// Depends on nothing; every other file of the block uses it.
`default_nettype none
package iba_pkg;
    localparam int NUM_DISK_BLOCKS = 256;
    localparam int BLOCK_BYTES     = 4096;
    localparam int MAX_FILES       = 16;
    localparam int BLK_W  = $clog2(NUM_DISK_BLOCKS);
    localparam int CNT_W  = $clog2(NUM_DISK_BLOCKS + 1);
    localparam int FID_W  = (MAX_FILES > 1) ? $clog2(MAX_FILES) : 1;
    localparam int SHIFT  = $clog2(BLOCK_BYTES);
    localparam int IDX_AW = FID_W + BLK_W;

    typedef enum logic [1:0] {
        OP_WRITE  = 2'd0,
        OP_DELETE = 2'd1,
        OP_READ   = 2'd2,
        OP_BAD    = 2'd3
    } op_t;

    typedef enum logic [1:0] {
        ST_OK        = 2'd0,
        ST_TOO_LARGE = 2'd1,
        ST_NO_SPACE  = 2'd2,
        ST_NOT_FOUND = 2'd3
    } status_t;

    typedef enum logic [3:0] {
        S_IDLE,
        S_DECODE,
        S_REL_RD,
        S_REL_FREE,
        S_SCAN_RD,
        S_SCAN_CHK,
        S_RB_RD,
        S_RB_FREE,
        S_RD_START,
        S_RD_IDX,
        S_RD_IDX_WAIT,
        S_DONE
    } state_t;

    // Access request from the controller to the block-list memory.
    typedef struct packed {
        logic              we;
        logic [IDX_AW-1:0] addr;
        logic [BLK_W-1:0]  wdata;
    } idx_req_t;

    // Access request from the controller to the free bitmap.
    typedef struct packed {
        logic             we;
        logic [BLK_W-1:0] addr;
        logic             wdata;
    } map_req_t;
endpackage
`default_nettype wire

@@ rtl/core/iba_index_ram.sv @@
// Block-list memory: one row of block numbers per file, registered read.
// Depends on iba_pkg.
`default_nettype none
module iba_index_ram (
    input  wire logic                      clk,
    input  wire iba_pkg::idx_req_t         req,
    output logic [iba_pkg::BLK_W-1:0]      rdata
);
    logic [iba_pkg::BLK_W-1:0] mem [iba_pkg::MAX_FILES*iba_pkg::NUM_DISK_BLOCKS];

    // Write, or read with registered data.
    always_ff @(posedge clk)
    begin
        if (req.we)
            mem[req.addr] <= req.wdata;
        rdata <= mem[req.addr];
    end
endmodule
`default_nettype wire

@@ rtl/core/iba_free_map.sv @@
// Free bitmap: one bit per disk block, 1 means allocated, registered read.
// Depends on iba_pkg. Cleared by a sweep after reset.
`default_nettype none
module iba_free_map (
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire iba_pkg::map_req_t req,
    output logic                   rdata,
    output logic                   clear_done
);
    logic mem [iba_pkg::NUM_DISK_BLOCKS];
    logic [iba_pkg::CNT_W-1:0] clr_reg;

    // Clearing pointer runs once over all blocks after reset.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            clr_reg <= '0;
        else if (!clear_done)
            clr_reg <= clr_reg + 1'b1;
    end

    assign clear_done = (clr_reg == iba_pkg::CNT_W'(iba_pkg::NUM_DISK_BLOCKS));

    // Memory port: the sweep owns it until it ends.
    always_ff @(posedge clk)
    begin
        if (!clear_done)
            mem[clr_reg[iba_pkg::BLK_W-1:0]] <= 1'b0;
        else if (req.we)
            mem[req.addr] <= req.wdata;
        rdata <= mem[req.addr];
    end
endmodule
`default_nettype wire

@@ rtl/core/indexed_block_allocator.sv @@
// Indexed block allocator top level: request sequencer around the free bitmap
// and block-list memories. Depends on iba_pkg, iba_free_map, iba_index_ram.
// Errors go from decode straight to the result; a read fetches the list head
// and the indexed entry; a delete walks the list and frees each block; a create
// frees an old file's blocks, then scans the bitmap and rolls back on no space.
// One request at a time. Reset: files vanish at once, bitmap is swept clear.
`default_nettype none
module indexed_block_allocator (
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        s_tvalid,
    output logic             s_tready,
    // tdata: op[1:0], file_id[5:2], byte_size[29:6], block_index[37:30]
    input  wire logic [39:0] s_tdata,
    output logic             m_tvalid,
    input  wire logic        m_tready,
    // tdata: status[1:0], block_number[9:2], first_block[17:10],
    // stored_size[38:18], file_block_count[47:39], used_blocks[56:48]
    output logic [63:0]      m_tdata
);
    localparam int BW    = iba_pkg::BLK_W;
    localparam int CW    = iba_pkg::CNT_W;
    localparam int FW    = iba_pkg::FID_W;
    localparam int MAX_F = iba_pkg::MAX_FILES;

    iba_pkg::state_t state_reg, state_next;
    iba_pkg::idx_req_t idx_req;
    iba_pkg::map_req_t map_req;
    logic [BW-1:0] idx_rdata;
    logic          map_rdata;
    logic          clear_done;

    iba_pkg::op_t op_reg;
    logic [3:0]  fid_reg;
    logic [23:0] size_reg;
    logic [7:0]  bidx_reg;
    logic [MAX_F-1:0] valid_reg;
    logic [20:0] bytes_reg [MAX_F];
    logic [CW-1:0] nblk_reg [MAX_F];
    logic [CW-1:0] used_reg;
    logic [CW-1:0] k_reg;      // list position walked or filled
    logic [CW-1:0] scan_reg;   // bitmap scan pointer
    logic [CW-1:0] need_reg;
    iba_pkg::status_t st_reg;
    logic [7:0]  bnum_reg, start_reg;
    logic [20:0] sbytes_reg;
    logic [8:0]  nout_reg;
    logic        out_valid_reg;

    logic [FW-1:0] fid;
    logic          id_ok;
    logic [24:0]   need_w;
    logic [CW-1:0] cur_n;
    logic          commit;
    logic [20:0]   sat_bytes;

    iba_free_map u_map (
        .clk(clk), .rst_n(rst_n), .req(map_req), .rdata(map_rdata),
        .clear_done(clear_done)
    );
    iba_index_ram u_idx (.clk(clk), .req(idx_req), .rdata(idx_rdata));

    assign fid       = fid_reg[FW-1:0];
    assign id_ok     = ({28'd0, fid_reg} < 32'(iba_pkg::MAX_FILES));
    assign need_w    = ({1'b0, size_reg} + 25'(iba_pkg::BLOCK_BYTES - 1)) >> iba_pkg::SHIFT;
    assign cur_n     = nblk_reg[fid];
    assign commit    = (state_reg == iba_pkg::S_SCAN_RD) && (k_reg == need_reg);
    assign sat_bytes = (size_reg > 24'h1FFFFF) ? 21'h1FFFFF : size_reg[20:0];

    assign s_tready = (state_reg == iba_pkg::S_IDLE) && clear_done && !out_valid_reg;
    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {7'd0, used_reg, nout_reg, sbytes_reg, start_reg, bnum_reg, st_reg};

    // Next state.
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            iba_pkg::S_IDLE:
                if (s_tvalid && s_tready)
                    state_next = iba_pkg::S_DECODE;
            iba_pkg::S_DECODE:
                if (!id_ok || op_reg == iba_pkg::OP_BAD)
                    state_next = iba_pkg::S_DONE;
                else if (op_reg == iba_pkg::OP_WRITE)
                begin
                    if (need_w > 25'(iba_pkg::NUM_DISK_BLOCKS))
                        state_next = iba_pkg::S_DONE;
                    else
                        state_next = valid_reg[fid] ? iba_pkg::S_REL_RD
                                                    : iba_pkg::S_SCAN_RD;
                end
                else if (!valid_reg[fid])
                    state_next = iba_pkg::S_DONE;
                else
                    state_next = (op_reg == iba_pkg::OP_DELETE) ?
                                 iba_pkg::S_REL_RD : iba_pkg::S_RD_START;
            iba_pkg::S_REL_RD:
                state_next = (k_reg == cur_n) ?
                    ((op_reg == iba_pkg::OP_WRITE) ? iba_pkg::S_SCAN_RD : iba_pkg::S_DONE)
                    : iba_pkg::S_REL_FREE;
            iba_pkg::S_REL_FREE: state_next = iba_pkg::S_REL_RD;
            iba_pkg::S_SCAN_RD:
                if (k_reg == need_reg)
                    state_next = iba_pkg::S_DONE;
                else if (scan_reg == CW'(iba_pkg::NUM_DISK_BLOCKS))
                    state_next = iba_pkg::S_RB_RD;
                else
                    state_next = iba_pkg::S_SCAN_CHK;
            iba_pkg::S_SCAN_CHK: state_next = iba_pkg::S_SCAN_RD;
            iba_pkg::S_RB_RD:
                state_next = (k_reg == '0) ? iba_pkg::S_DONE : iba_pkg::S_RB_FREE;
            iba_pkg::S_RB_FREE: state_next = iba_pkg::S_RB_RD;
            iba_pkg::S_RD_START: state_next = iba_pkg::S_RD_IDX;
            iba_pkg::S_RD_IDX: state_next = iba_pkg::S_RD_IDX_WAIT;
            iba_pkg::S_RD_IDX_WAIT: state_next = iba_pkg::S_DONE;
            iba_pkg::S_DONE: state_next = iba_pkg::S_IDLE;
            default: state_next = iba_pkg::S_IDLE;
        endcase
    end

    // Memory requests. A list entry read in one state is used in the next.
    always_comb
    begin
        idx_req = '0;
        map_req = '0;
        unique case (state_reg)
            iba_pkg::S_REL_RD:
                idx_req.addr = {fid, k_reg[BW-1:0]};
            iba_pkg::S_RB_RD:
                idx_req.addr = {fid, BW'(k_reg - 1'b1)};
            iba_pkg::S_REL_FREE, iba_pkg::S_RB_FREE:
            begin
                map_req.we    = 1'b1;
                map_req.addr  = idx_rdata;
                map_req.wdata = 1'b0;
            end
            iba_pkg::S_SCAN_RD: map_req.addr = scan_reg[BW-1:0];
            iba_pkg::S_SCAN_CHK:
            begin
                map_req.addr  = scan_reg[BW-1:0];
                map_req.we    = !map_rdata;
                map_req.wdata = 1'b1;
                idx_req.we    = !map_rdata;
                idx_req.addr  = {fid, k_reg[BW-1:0]};
                idx_req.wdata = scan_reg[BW-1:0];
            end
            iba_pkg::S_RD_START: idx_req.addr = {fid, {BW{1'b0}}};
            iba_pkg::S_RD_IDX: idx_req.addr = {fid, bidx_reg[BW-1:0]};
            default: ;
        endcase
    end

    // File size and block count records, read only while the file is valid.
    always_ff @(posedge clk)
    begin
        if (commit)
        begin
            bytes_reg[fid] <= sat_bytes;
            nblk_reg[fid]  <= need_reg;
        end
    end

    // Sequencer, valid flags, used count and result register.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= iba_pkg::S_IDLE;
            valid_reg     <= '0;
            used_reg      <= '0;
            out_valid_reg <= 1'b0;
            k_reg <= '0; scan_reg <= '0; need_reg <= '0;
            op_reg <= iba_pkg::OP_WRITE; fid_reg <= '0; size_reg <= '0; bidx_reg <= '0;
            st_reg <= iba_pkg::ST_OK; bnum_reg <= '0; start_reg <= '0;
            sbytes_reg <= '0; nout_reg <= '0;
        end
        else
        begin
            state_reg <= state_next;
            if (state_reg == iba_pkg::S_DONE)
                out_valid_reg <= 1'b1;
            else if (m_tready)
                out_valid_reg <= 1'b0;
            unique case (state_reg)
                iba_pkg::S_IDLE:
                    if (s_tvalid && s_tready)
                    begin
                        op_reg   <= iba_pkg::op_t'(s_tdata[1:0]);
                        fid_reg  <= s_tdata[5:2];
                        size_reg <= s_tdata[29:6];
                        bidx_reg <= s_tdata[37:30];
                        st_reg   <= iba_pkg::ST_OK;
                        bnum_reg <= '0; start_reg <= '0; sbytes_reg <= '0; nout_reg <= '0;
                    end
                iba_pkg::S_DECODE:
                begin
                    k_reg    <= '0;
                    scan_reg <= '0;
                    need_reg <= CW'(need_w);
                    if (!id_ok || op_reg == iba_pkg::OP_BAD)
                        st_reg <= iba_pkg::ST_NOT_FOUND;
                    else if (op_reg == iba_pkg::OP_WRITE)
                    begin
                        if (need_w > 25'(iba_pkg::NUM_DISK_BLOCKS))
                            st_reg <= iba_pkg::ST_TOO_LARGE;
                    end
                    else if (!valid_reg[fid])
                        st_reg <= iba_pkg::ST_NOT_FOUND;
                end
                iba_pkg::S_REL_RD:
                    if (k_reg == cur_n)
                    begin
                        valid_reg[fid] <= 1'b0;
                        k_reg <= '0;
                    end
                iba_pkg::S_REL_FREE:
                begin
                    k_reg    <= k_reg + 1'b1;
                    used_reg <= used_reg - 1'b1;
                end
                iba_pkg::S_SCAN_RD:
                    if (k_reg == need_reg)
                    begin
                        valid_reg[fid] <= 1'b1;
                        used_reg       <= used_reg + need_reg;
                        sbytes_reg     <= sat_bytes;
                        nout_reg       <= 9'(need_reg);
                    end
                    else if (scan_reg == CW'(iba_pkg::NUM_DISK_BLOCKS))
                    begin
                        st_reg    <= iba_pkg::ST_NO_SPACE;
                        start_reg <= '0;
                    end
                iba_pkg::S_SCAN_CHK:
                begin
                    scan_reg <= scan_reg + 1'b1;
                    if (!map_rdata)
                        k_reg <= k_reg + 1'b1;
                    if (!map_rdata && k_reg == '0)
                        start_reg <= scan_reg[BW-1:0];
                end
                iba_pkg::S_RB_FREE: k_reg <= k_reg - 1'b1;
                iba_pkg::S_RD_IDX:
                begin
                    start_reg  <= (cur_n != '0) ? idx_rdata : 8'd0;
                    nout_reg   <= 9'(cur_n);
                    sbytes_reg <= bytes_reg[fid];
                end
                iba_pkg::S_RD_IDX_WAIT:
                    if ({1'b0, bidx_reg} < cur_n)
                        bnum_reg <= idx_rdata;
                default: ;
            endcase
        end
    end

    // The block-list walk never frees more blocks than are in use.
    assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == iba_pkg::S_REL_FREE |-> used_reg != '0)
        else $error("free with zero used count");
    // No request is taken while a result waits.
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg |-> !s_tready)
        else $error("accept while result pending");
    // A result is raised only from the final state.
    assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_valid_reg) |-> $past(state_reg) == iba_pkg::S_DONE)
        else $error("result raised outside done state");
endmodule
`default_nettype wire
